FILE: design/two_beam_passage_direction_logger_defines.svh
// Assertion macros shared by the passage direction logger RTL.
`ifndef TWO_BEAM_PASSAGE_DIRECTION_LOGGER_DEFINES_SVH
`define TWO_BEAM_PASSAGE_DIRECTION_LOGGER_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define TBPDL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define TBPDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tbpdl_pkg.sv
// Types and constants for the two-beam passage direction logger.
package tbpdl_pkg;

    // Field widths of the request and result items.
    localparam int DIST_W  = 16;
    localparam int COUNT_W = 8;
    localparam int TIME_W  = 16;
    localparam int RSLOT_W = 4;
    localparam int PHASE_W = 3;

    // Packed stream widths (tdata padded to whole bytes).
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    // Configuration register map and reset values.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_MIN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_MAX = 1'd1;
    localparam logic [DIST_W-1:0] NEAR_MIN_RESET = 16'd10;
    localparam logic [DIST_W-1:0] NEAR_MAX_RESET = 16'd1000;

    // Time base: seconds advance by 2/5 per sample.
    localparam logic [PHASE_W-1:0] PHASE_STEP = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_WRAP = 3'd5;

    // Request kinds carried in s_tuser.
    typedef enum logic [1:0] {
        MODE_SAMPLE    = 2'd0,
        MODE_LINK_UP   = 2'd1,
        MODE_LINK_DOWN = 2'd2,
        MODE_READ      = 2'd3
    } mode_t;

    // Reported passage direction.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_IN   = 2'd1,
        DIR_OUT  = 2'd2
    } dir_t;

endpackage

FILE: design/two_beam_passage_direction_logger.sv
// Two-beam passage direction logger: beam qualification, direction tracking and stamp log.
//
//  Channel  | Ports                                    | Contents
//  ---------+------------------------------------------+-------------------------------------
//  request  | s_tvalid s_tready s_tdata[39:0] s_tuser  | distances, read slot; tuser = mode
//  result   | m_tvalid m_tready m_tdata[71:0]          | direction, blocked flags, totals, time
//  config   | cfg_we cfg_index cfg_wdata[15:0]         | near_min (0), near_max (1)
//
// One request per cycle while s_tready is high: each request is processed in the cycle it is
// accepted and its result lands in the output register in the next cycle.
// The single output register sets the rate; s_tready is low only while a result waits
// and m_tready is low.
// Synchronous active-low reset clears the beam flags, counts, time base, link flag and
// the stamp valid bits, so every log slot reads zero until written.
`include "two_beam_passage_direction_logger_defines.svh"

module two_beam_passage_direction_logger
    import tbpdl_pkg::*;
#(
    parameter int SLOTS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIST_W-1:0]      cfg_wdata,
    // Request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata from bit 0: dist_left[15:0], dist_right[31:16], read_slot[35:32], zero pad
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // s_tuser from bit 0: mode[1:0]
    input  logic [S_TUSER_W-1:0]   s_tuser,
    // Result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata from bit 0: direction[1:0], left_blocked[2], right_blocked[3],
    // in_total[11:4], out_total[19:12], elapsed_seconds[35:20],
    // slot_in_time[51:36], slot_out_time[67:52], zero pad
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [RSLOT_W:0] SLOT_LIMIT = (RSLOT_W + 1)'(SLOTS);

    // Configuration registers
    logic [DIST_W-1:0] near_min_reg;
    logic [DIST_W-1:0] near_max_reg;

    // Tracking state
    logic               left_only_reg, left_only_next;
    logic               right_only_reg, right_only_next;
    logic               both_seen_reg, both_seen_next;
    logic               event_logged_reg, event_logged_next;
    logic               link_up_reg, link_up_next;
    logic [COUNT_W-1:0] in_count_reg, in_count_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [SLOT_W-1:0]  in_ptr_reg, in_ptr_next;
    logic [SLOT_W-1:0]  out_ptr_reg, out_ptr_next;
    logic [TIME_W-1:0]  second_count_reg, second_count_next;
    logic [PHASE_W-1:0] second_phase_reg, second_phase_next;

    // Stamp log with per-entry valid bits
    logic [TIME_W-1:0] in_stamp_reg [SLOTS];
    logic [TIME_W-1:0] out_stamp_reg [SLOTS];
    logic [SLOTS-1:0]  in_valid_reg;
    logic [SLOTS-1:0]  out_valid_reg;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] result;

    // Request fields and combinational results
    mode_t              mode;
    logic [DIST_W-1:0]  dist_left;
    logic [DIST_W-1:0]  dist_right;
    logic [RSLOT_W-1:0] read_slot;
    logic [SLOT_W-1:0]  read_idx;
    logic               slot_ok;
    logic               accept;
    logic               left_hit;
    logic               right_hit;
    logic               left_blocked;
    logic               right_blocked;
    dir_t               direction;
    logic               log_in;
    logic               log_out;
    logic [TIME_W-1:0]  slot_in_time;
    logic [TIME_W-1:0]  slot_out_time;
    logic [PHASE_W-1:0] phase_sum;

    assign mode       = mode_t'(s_tuser);
    assign dist_left  = s_tdata[15:0];
    assign dist_right = s_tdata[31:16];
    assign read_slot  = s_tdata[35:32];
    assign read_idx   = read_slot[SLOT_W-1:0];
    assign slot_ok    = {1'b0, read_slot} < SLOT_LIMIT;

    // Handshake: the output register frees up when empty or being taken.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // Near-window qualification of both beams.
    assign left_hit  = (dist_left > near_min_reg) && (dist_left < near_max_reg);
    assign right_hit = (dist_right > near_min_reg) && (dist_right < near_max_reg);
    assign phase_sum = second_phase_reg + PHASE_STEP;

    // Direction tracking, counts, time base and link flag.
    always_comb begin
        left_only_next    = left_only_reg;
        right_only_next   = right_only_reg;
        both_seen_next    = both_seen_reg;
        event_logged_next = event_logged_reg;
        link_up_next      = link_up_reg;
        in_count_next     = in_count_reg;
        out_count_next    = out_count_reg;
        in_ptr_next       = in_ptr_reg;
        out_ptr_next      = out_ptr_reg;
        second_count_next = second_count_reg;
        second_phase_next = second_phase_reg;
        direction         = DIR_NONE;
        left_blocked      = 1'b0;
        right_blocked     = 1'b0;
        log_in            = 1'b0;
        log_out           = 1'b0;
        slot_in_time      = '0;
        slot_out_time     = '0;
        case (mode)
            MODE_SAMPLE: begin
                left_blocked  = left_hit;
                right_blocked = right_hit;
                if (left_hit && !right_hit) begin
                    if ((both_seen_reg || right_only_reg) && !event_logged_reg) begin
                        event_logged_next = 1'b1;
                        direction         = DIR_IN;
                    end
                    left_only_next  = 1'b1;
                    right_only_next = 1'b0;
                    both_seen_next  = 1'b0;
                end else if (!left_hit && right_hit) begin
                    if ((both_seen_reg || left_only_reg) && !event_logged_reg) begin
                        event_logged_next = 1'b1;
                        direction         = DIR_OUT;
                    end
                    left_only_next  = 1'b0;
                    right_only_next = 1'b1;
                    both_seen_next  = 1'b0;
                end else if (left_hit && right_hit) begin
                    // Both beams at once: the prior single beam decides, logged flag untested.
                    if (left_only_reg) begin
                        direction         = DIR_OUT;
                        event_logged_next = 1'b1;
                    end else if (right_only_reg) begin
                        direction         = DIR_IN;
                        event_logged_next = 1'b1;
                    end
                    left_only_next  = 1'b0;
                    right_only_next = 1'b0;
                    both_seen_next  = 1'b1;
                end else begin
                    left_only_next    = 1'b0;
                    right_only_next   = 1'b0;
                    both_seen_next    = 1'b0;
                    event_logged_next = 1'b0;
                end
                // Log events only while the link is down; the slot pointer tracks count mod SLOTS.
                log_in  = !link_up_reg && (direction == DIR_IN);
                log_out = !link_up_reg && (direction == DIR_OUT);
                if (log_in) begin
                    in_count_next = in_count_reg + 1'b1;
                    if (in_count_reg == '1 || in_ptr_reg == LAST_SLOT) begin
                        in_ptr_next = '0;
                    end else begin
                        in_ptr_next = in_ptr_reg + 1'b1;
                    end
                end
                if (log_out) begin
                    out_count_next = out_count_reg + 1'b1;
                    if (out_count_reg == '1 || out_ptr_reg == LAST_SLOT) begin
                        out_ptr_next = '0;
                    end else begin
                        out_ptr_next = out_ptr_reg + 1'b1;
                    end
                end
                // Seconds advance by two fifths per sample.
                if (phase_sum >= PHASE_WRAP) begin
                    second_phase_next = phase_sum - PHASE_WRAP;
                    second_count_next = second_count_reg + 1'b1;
                end else begin
                    second_phase_next = phase_sum;
                end
            end
            MODE_LINK_UP: begin
                link_up_next = 1'b1;
            end
            MODE_LINK_DOWN: begin
                link_up_next   = 1'b0;
                in_count_next  = '0;
                out_count_next = '0;
                in_ptr_next    = '0;
                out_ptr_next   = '0;
            end
            MODE_READ: begin
                if (slot_ok) begin
                    slot_in_time  = in_valid_reg[read_idx] ? in_stamp_reg[read_idx] : '0;
                    slot_out_time = out_valid_reg[read_idx] ? out_stamp_reg[read_idx] : '0;
                end
            end
            default: begin
                direction = DIR_NONE;
            end
        endcase
    end

    // Pack the result item.
    assign result = {4'b0, slot_out_time, slot_in_time, second_count_reg,
                     out_count_next, in_count_next, right_blocked, left_blocked,
                     2'(direction)};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_min_reg <= NEAR_MIN_RESET;
            near_max_reg <= NEAR_MAX_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_NEAR_MIN: near_min_reg <= cfg_wdata;
                CFG_NEAR_MAX: near_max_reg <= cfg_wdata;
                default: begin
                    near_min_reg <= near_min_reg;
                end
            endcase
        end
    end

    // Tracking state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_only_reg    <= 1'b0;
            right_only_reg   <= 1'b0;
            both_seen_reg    <= 1'b0;
            event_logged_reg <= 1'b0;
            link_up_reg      <= 1'b0;
            in_count_reg     <= '0;
            out_count_reg    <= '0;
            in_ptr_reg       <= '0;
            out_ptr_reg      <= '0;
            second_count_reg <= '0;
            second_phase_reg <= '0;
            in_valid_reg     <= '0;
            out_valid_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                left_only_reg    <= left_only_next;
                right_only_reg   <= right_only_next;
                both_seen_reg    <= both_seen_next;
                event_logged_reg <= event_logged_next;
                link_up_reg      <= link_up_next;
                in_count_reg     <= in_count_next;
                out_count_reg    <= out_count_next;
                in_ptr_reg       <= in_ptr_next;
                out_ptr_reg      <= out_ptr_next;
                second_count_reg <= second_count_next;
                second_phase_reg <= second_phase_next;
                if (log_in) begin
                    in_valid_reg[in_ptr_reg] <= 1'b1;
                end
                if (log_out) begin
                    out_valid_reg[out_ptr_reg] <= 1'b1;
                end
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Stamp data and result payload.
    always_ff @(posedge aclk) begin
        if (accept && log_in) begin
            in_stamp_reg[in_ptr_reg] <= second_count_reg;
        end
        if (accept && log_out) begin
            out_stamp_reg[out_ptr_reg] <= second_count_reg;
        end
        if (accept) begin
            m_tdata_reg <= result;
        end
    end

    // Checks on the tracking logic.
    `TBPDL_ASSERT_NOW(a_flags_exclusive, 1'b1,
        $onehot0({left_only_reg, right_only_reg, both_seen_reg}),
        "beam history flags are not mutually exclusive")
    `TBPDL_ASSERT_NEXT(a_nonsample_quiet, accept && (mode != MODE_SAMPLE),
        m_tdata_reg[3:0] == 4'b0000,
        "non-sample request reported a direction or blocked beam")
    `TBPDL_ASSERT_NEXT(a_slot_times_read_only, accept && (mode != MODE_READ),
        m_tdata_reg[67:36] == 32'd0,
        "slot times nonzero outside read requests")
    `TBPDL_ASSERT_NEXT(a_link_down_clears, accept && (mode == MODE_LINK_DOWN),
        (in_count_reg == '0) && (out_count_reg == '0) && !link_up_reg,
        "link down did not clear the counts and link flag")

endmodule

FILE: tb/two_beam_passage_direction_logger_tb.sv
// Self-checking testbench for the two-beam passage direction logger with a built-in predictor.
module two_beam_passage_direction_logger_tb
    import tbpdl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOG_SLOTS            = 10;
    localparam int RECEIVER_HOLD_CYCLES = 64;
    localparam int WATCHDOG_LIMIT       = 2000;

    // One decoded result of the block.
    typedef struct packed {
        dir_t        direction;
        logic        left_blocked;
        logic        right_blocked;
        logic [7:0]  in_total;
        logic [7:0]  out_total;
        logic [15:0] elapsed_seconds;
        logic [15:0] slot_in_time;
        logic [15:0] slot_out_time;
    } passage_result_t;

    // One row of the directed request table.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] dist_left;
        logic [15:0] dist_right;
        logic [3:0]  read_slot;
        logic        expect_zero;
    } directed_request_t;

    // Directed requests. Rows marked with a set last field expect an all-zero result.
    localparam directed_request_t DIRECTED_ROWS [25] = '{
        '{MODE_READ,      16'd0,     16'd0,     4'd0,  1'b1},
        '{MODE_READ,      16'd0,     16'd0,     4'd15, 1'b1},
        '{MODE_SAMPLE,    16'd0,     16'd65535, 4'd0,  1'b1},
        '{MODE_SAMPLE,    16'd10,    16'd1000,  4'd5,  1'b1},
        '{MODE_SAMPLE,    16'd11,    16'd999,   4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd0,     16'd0,     4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd500,   16'd5,     4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd500,   16'd500,   4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd500,   16'd5,     4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd500,   16'd500,   4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd5,     16'd500,   4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd0,     16'd0,     4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd5,     16'd500,   4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd500,   16'd5,     4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd1001,  16'd1001,  4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd5,     16'd500,   4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd999,   16'd11,    4'd0,  1'b0},
        '{MODE_READ,      16'd0,     16'd0,     4'd0,  1'b0},
        '{MODE_LINK_UP,   16'd0,     16'd0,     4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd999,   16'd1,     4'd0,  1'b0},
        '{MODE_SAMPLE,    16'd1,     16'd999,   4'd0,  1'b0},
        '{MODE_LINK_DOWN, 16'd0,     16'd0,     4'd0,  1'b0},
        '{MODE_READ,      16'd0,     16'd0,     4'd1,  1'b0},
        '{MODE_READ,      16'd0,     16'd0,     4'd10, 1'b0},
        '{MODE_SAMPLE,    16'd65535, 16'd65535, 4'd0,  1'b0}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DIST_W-1:0]      cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Stimulus control shared between the sender, the receiver and the checker.
    logic src_idle_on      = 1'b0;
    logic sink_idle_on     = 1'b0;
    logic receiver_hold    = 1'b0;
    logic row_expects_zero = 1'b0;
    int   requests_sent    = 0;
    int   mismatch_count   = 0;

    passage_result_t expected_reports[$];

    // Predictor copy of the window registers and of the block state.
    logic [15:0] win_lo;
    logic [15:0] win_hi;
    logic        beam_left_only;
    logic        beam_right_only;
    logic        beam_both;
    logic        passage_logged;
    logic        link_is_up;
    logic [7:0]  in_tally;
    logic [7:0]  out_tally;
    logic [15:0] seconds_now;
    logic [2:0]  seconds_phase;
    logic [15:0] in_stamp_log  [LOG_SLOTS];
    logic [15:0] out_stamp_log [LOG_SLOTS];

    two_beam_passage_direction_logger #(
        .SLOTS(LOG_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Put the predictor into its after-reset state.
    task automatic clear_logger_model();
        win_lo          = NEAR_MIN_RESET;
        win_hi          = NEAR_MAX_RESET;
        beam_left_only  = 1'b0;
        beam_right_only = 1'b0;
        beam_both       = 1'b0;
        passage_logged  = 1'b0;
        link_is_up      = 1'b0;
        in_tally        = '0;
        out_tally       = '0;
        seconds_now     = '0;
        seconds_phase   = '0;
        for (int i = 0; i < LOG_SLOTS; i++) begin
            in_stamp_log[i]  = '0;
            out_stamp_log[i] = '0;
        end
    endtask

    // Advance the predictor by one request and return the result it must produce.
    function automatic passage_result_t predict_passage(mode_t mode, logic [15:0] dl,
                                                        logic [15:0] dr, logic [3:0] slot);
        passage_result_t r;
        logic lb;
        logic rb;
        r = '0;
        r.elapsed_seconds = seconds_now;
        case (mode)
            MODE_SAMPLE: begin
                lb = (dl > win_lo) && (dl < win_hi);
                rb = (dr > win_lo) && (dr < win_hi);
                r.left_blocked  = lb;
                r.right_blocked = rb;
                if (lb && !rb) begin
                    if ((beam_both || beam_right_only) && !passage_logged) begin
                        passage_logged = 1'b1;
                        r.direction    = DIR_IN;
                    end
                    beam_left_only  = 1'b1;
                    beam_right_only = 1'b0;
                    beam_both       = 1'b0;
                end else if (!lb && rb) begin
                    if ((beam_both || beam_left_only) && !passage_logged) begin
                        passage_logged = 1'b1;
                        r.direction    = DIR_OUT;
                    end
                    beam_left_only  = 1'b0;
                    beam_right_only = 1'b1;
                    beam_both       = 1'b0;
                end else if (lb && rb) begin
                    // Both beams at once: the logged flag is not consulted here.
                    if (beam_left_only) begin
                        r.direction    = DIR_OUT;
                        passage_logged = 1'b1;
                    end else if (beam_right_only) begin
                        r.direction    = DIR_IN;
                        passage_logged = 1'b1;
                    end
                    beam_left_only  = 1'b0;
                    beam_right_only = 1'b0;
                    beam_both       = 1'b1;
                end else begin
                    beam_left_only  = 1'b0;
                    beam_right_only = 1'b0;
                    beam_both       = 1'b0;
                    passage_logged  = 1'b0;
                end
                // Events are stamped into the ring only while the link is down.
                if (!link_is_up) begin
                    if (r.direction == DIR_IN) begin
                        in_stamp_log[in_tally % LOG_SLOTS] = seconds_now;
                        in_tally = in_tally + 8'd1;
                    end else if (r.direction == DIR_OUT) begin
                        out_stamp_log[out_tally % LOG_SLOTS] = seconds_now;
                        out_tally = out_tally + 8'd1;
                    end
                end
                seconds_phase = seconds_phase + PHASE_STEP;
                if (seconds_phase >= PHASE_WRAP) begin
                    seconds_phase = seconds_phase - PHASE_WRAP;
                    seconds_now   = seconds_now + 16'd1;
                end
            end
            MODE_LINK_UP: begin
                link_is_up = 1'b1;
            end
            MODE_LINK_DOWN: begin
                link_is_up = 1'b0;
                in_tally   = '0;
                out_tally  = '0;
            end
            default: begin
                if (slot < LOG_SLOTS) begin
                    r.slot_in_time  = in_stamp_log[slot];
                    r.slot_out_time = out_stamp_log[slot];
                end
            end
        endcase
        r.in_total  = in_tally;
        r.out_total = out_tally;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Checker: compare each result with the oldest expectation, then record new requests.
    always @(posedge aclk) begin
        passage_result_t want;
        passage_result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.direction       = dir_t'(m_tdata[1:0]);
                got.left_blocked    = m_tdata[2];
                got.right_blocked   = m_tdata[3];
                got.in_total        = m_tdata[11:4];
                got.out_total       = m_tdata[19:12];
                got.elapsed_seconds = m_tdata[35:20];
                got.slot_in_time    = m_tdata[51:36];
                got.slot_out_time   = m_tdata[67:52];
                if (expected_reports.size() == 0) begin
                    $error("result with no request waiting, m_tdata %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("direction", 32'(want.direction), 32'(got.direction));
                    check_field("left_blocked", 32'(want.left_blocked),
                                32'(got.left_blocked));
                    check_field("right_blocked", 32'(want.right_blocked),
                                32'(got.right_blocked));
                    check_field("in_total", 32'(want.in_total), 32'(got.in_total));
                    check_field("out_total", 32'(want.out_total), 32'(got.out_total));
                    check_field("elapsed_seconds", 32'(want.elapsed_seconds),
                                32'(got.elapsed_seconds));
                    check_field("slot_in_time", 32'(want.slot_in_time),
                                32'(got.slot_in_time));
                    check_field("slot_out_time", 32'(want.slot_out_time),
                                32'(got.slot_out_time));
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_passage(mode_t'(s_tuser), s_tdata[15:0], s_tdata[31:16],
                                       s_tdata[35:32]);
                if (row_expects_zero) begin
                    want = '0;
                end
                expected_reports.push_back(want);
            end
        end
    end

    // Receiver: random stall bursts, and a long hold-off when asked for one.
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (receiver_hold) begin
                m_tready = 1'b0;
                repeat (RECEIVER_HOLD_CYCLES) @(negedge aclk);
                receiver_hold = 1'b0;
                m_tready = 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                stall = $urandom_range(1, 8);
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offer one request and hold it until the block takes it. Entered and left at a falling edge.
    task automatic send_request(input mode_t mode, input logic [15:0] dl,
                                input logic [15:0] dr, input logic [3:0] slot,
                                input logic expect_zero);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid         = 1'b1;
        s_tuser          = mode;
        s_tdata          = {4'b0000, slot, dr, dl};
        row_expects_zero = expect_zero;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        requests_sent++;
        @(negedge aclk);
    endtask

    // Distance on or off the near window, with some picks right at its edges.
    function automatic logic [15:0] beam_dist(input logic blocked);
        if (blocked && win_hi > win_lo + 1) begin
            if ($urandom_range(0, 5) == 0) begin
                return $urandom_range(0, 1) ? win_lo + 16'd1 : win_hi - 16'd1;
            end
            return 16'($urandom_range(win_lo + 1, win_hi - 1));
        end
        if ($urandom_range(0, 5) == 0) begin
            return $urandom_range(0, 1) ? win_lo : win_hi;
        end
        if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom_range(0, win_lo));
        end
        return 16'($urandom_range(win_hi, 65535));
    endfunction

    task automatic send_sample(input logic lb, input logic rb);
        send_request(MODE_SAMPLE, beam_dist(lb), beam_dist(rb), 4'($urandom_range(0, 15)),
                     1'b0);
    endtask

    task automatic send_read();
        send_request(MODE_READ, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     4'($urandom_range(0, 15)), 1'b0);
    endtask

    // A well-formed passage: first beam, optionally both, second beam, then clear.
    task automatic send_passage(input logic inward);
        repeat ($urandom_range(1, 3)) send_sample(!inward, inward);
        if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 3)) send_sample(1'b1, 1'b1);
        end
        repeat ($urandom_range(1, 3)) send_sample(inward, !inward);
        repeat ($urandom_range(1, 2)) send_sample(1'b0, 1'b0);
    endtask

    // Noise: link changes, raw distances and broken beam sequences.
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            send_request(MODE_LINK_UP, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)), 1'b0);
        end else if (pick == 1) begin
            send_request(MODE_LINK_DOWN, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)), 1'b0);
        end else if (pick < 6) begin
            send_request(MODE_SAMPLE, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)), 1'b0);
        end else begin
            send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_round(input int count, input logic src_idle, input logic sink_idle);
        int start;
        int pick;
        start        = requests_sent;
        src_idle_on  = src_idle;
        sink_idle_on = sink_idle;
        while (requests_sent - start < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_passage(1'($urandom_range(0, 1)));
            end else if (pick == 7) begin
                send_read();
            end else begin
                send_noise();
            end
        end
    endtask

    // Stop offering requests and wait until every expected result has come back.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
    endtask

    // Write both window registers while the block is idle.
    task automatic write_window(input logic [15:0] lo, input logic [15:0] hi);
        drain_results();
        repeat (2) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = CFG_NEAR_MIN;
        cfg_wdata = lo;
        @(negedge aclk);
        cfg_index = CFG_NEAR_MAX;
        cfg_wdata = hi;
        @(negedge aclk);
        cfg_we = 1'b0;
        win_lo = lo;
        win_hi = hi;
    endtask

    // Main sequence.
    initial begin
        int lo;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_NEAR_MIN;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_SAMPLE;
        clear_logger_model();
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed requests at the reset window.
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        foreach (DIRECTED_ROWS[i]) begin
            send_request(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].dist_left,
                         DIRECTED_ROWS[i].dist_right, DIRECTED_ROWS[i].read_slot,
                         DIRECTED_ROWS[i].expect_zero);
        end
        row_expects_zero = 1'b0;

        // Widest window, with a long receiver hold-off while requests keep coming.
        write_window(16'd0, 16'd65535);
        run_round(40, 1'b1, 1'b1);
        receiver_hold = 1'b1;
        run_round(80, 1'b1, 1'b0);
        drain_results();

        // Inverted and empty windows: nothing is ever blocked.
        write_window(16'd65535, 16'd0);
        run_round(40, 1'b0, 1'b1);
        write_window(16'd500, 16'd500);
        run_round(30, 1'b1, 1'b1);

        // Long unlinked run of alternating passages so that both counts wrap.
        write_window(NEAR_MIN_RESET, NEAR_MAX_RESET);
        send_request(MODE_LINK_DOWN, 16'd0, 16'd0, 4'd0, 1'b0);
        repeat (260) begin
            send_sample(1'b1, 1'b0);
            send_sample(1'b1, 1'b1);
            send_sample(1'b0, 1'b1);
            send_sample(1'b1, 1'b1);
            if ($urandom_range(0, 9) == 0) begin
                send_read();
            end
        end
        for (int s = 0; s < 16; s++) begin
            send_request(MODE_READ, 16'd0, 16'd0, s[3:0], 1'b0);
        end

        // Random windows.
        lo = $urandom_range(0, 2000);
        write_window(16'(lo), 16'(lo + $urandom_range(2, 3000)));
        run_round(80, 1'b1, 1'b0);
        write_window(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_round(80, 1'b0, 1'b0);
        write_window(16'd0, 16'd2);
        run_round(80, 1'b1, 1'b1);

        // Closing stretch without idling.
        lo = $urandom_range(0, 500);
        write_window(16'(lo), 16'(lo + $urandom_range(100, 4000)));
        run_round(120, 1'b0, 1'b0);

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/tbpdl_pkg.sv
design/two_beam_passage_direction_logger.sv
tb/two_beam_passage_direction_logger_tb.sv
